FILE: hw/rtl/fenwick_tree_mod_prefix_sum_core_assert.svh
// Assertion macros used by the checker file of the Fenwick prefix-sum core.
`ifndef FENWICK_TREE_MOD_PREFIX_SUM_CORE_ASSERT_SVH
`define FENWICK_TREE_MOD_PREFIX_SUM_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define FTM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define FTM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ftm_pkg.sv
// Shared constants, types and arithmetic helpers of the Fenwick prefix-sum core.
package ftm_pkg;

  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = ADDR_W + 2;
  localparam int POS_W  = 13;
  localparam int SIZE_W = 13;
  localparam int VAL_W  = 30;
  localparam int OPC_W  = 2;

  localparam logic [VAL_W-1:0]  MODULUS    = 30'd1000000007;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DEPTH);
  localparam logic [POS_W-1:0]  DEPTH_POS  = POS_W'(DEPTH);

  localparam logic [OPC_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OPC_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // Sum of two residues, reduced once below the modulus.
  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    logic [VAL_W:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, MODULUS};
    if (s >= {1'b0, MODULUS}) begin
      return d[VAL_W-1:0];
    end
    return s[VAL_W-1:0];
  endfunction

  // Lowest set bit of a tree index.
  function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] v);
    return v & (~v + IDX_W'(1));
  endfunction

endpackage

FILE: hw/rtl/ftm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ftm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/ftm_ctrl.sv
// Sequencer of the Fenwick prefix-sum core: tree walks, node updates and clearing.
module ftm_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ftm_pkg::OPC_W-1:0]    in_opcode,
  input  logic [ftm_pkg::POS_W-1:0]    in_position,
  input  logic [ftm_pkg::VAL_W-1:0]    in_addend,
  input  logic [ftm_pkg::SIZE_W-1:0]   size_in_use,
  input  logic [ftm_pkg::VAL_W-1:0]    rd_data,
  output ftm_pkg::mem_req_t            mem_req,
  output logic                         res_valid,
  output logic [ftm_pkg::VAL_W-1:0]    res_sum,
  input  logic                         res_ready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD    = 3'd1;
  localparam logic [2:0] ST_QUERY  = 3'd2;
  localparam logic [2:0] ST_RESULT = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;

  logic [2:0]                   state, state_next;
  logic [ftm_pkg::IDX_W-1:0]    idx, idx_next;
  logic [ftm_pkg::POS_W-1:0]    bound, bound_next;
  logic [ftm_pkg::VAL_W-1:0]    addv, addv_next;
  logic [ftm_pkg::VAL_W-1:0]    acc, acc_next;
  logic [ftm_pkg::ADDR_W-1:0]   clr_cnt, clr_cnt_next;

  logic                         accept;
  logic [ftm_pkg::POS_W-1:0]    bound_in;
  logic [ftm_pkg::POS_W-1:0]    pos_sat;
  logic [ftm_pkg::VAL_W-1:0]    mod_sum;
  logic [ftm_pkg::IDX_W-1:0]    up_next;
  logic [ftm_pkg::IDX_W-1:0]    dn_next;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign res_valid = (state == ST_RESULT);
  assign res_sum   = acc;

  assign bound_in = (size_in_use > ftm_pkg::DEPTH_POS) ? ftm_pkg::DEPTH_POS : size_in_use;
  assign pos_sat  = (in_position > ftm_pkg::DEPTH_POS) ? ftm_pkg::DEPTH_POS : in_position;

  // One modular adder serves both walks: node plus addend, or running sum plus node.
  assign mod_sum = ftm_pkg::mod_add(rd_data, (state == ST_ADD) ? addv : acc);
  assign up_next = idx + ftm_pkg::low_bit(idx);
  assign dn_next = idx - ftm_pkg::low_bit(idx);

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    bound_next   = bound;
    addv_next    = addv;
    acc_next     = acc;
    clr_cnt_next = clr_cnt;
    mem_req      = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            ftm_pkg::OP_ADD: begin
              if ((in_position != '0) && (in_position <= bound_in)) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = in_position[ftm_pkg::ADDR_W-1:0];
                idx_next        = ftm_pkg::IDX_W'(in_position);
                bound_next      = bound_in;
                addv_next       = ftm_pkg::mod_add(in_addend, '0);
                state_next      = ST_ADD;
              end
            end
            ftm_pkg::OP_QUERY: begin
              acc_next = '0;
              if (pos_sat == '0) begin
                state_next = ST_RESULT;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = pos_sat[ftm_pkg::ADDR_W-1:0];
                idx_next        = ftm_pkg::IDX_W'(pos_sat);
                state_next      = ST_QUERY;
              end
            end
            ftm_pkg::OP_CLEAR: begin
              clr_cnt_next = '0;
              state_next   = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        // Walk nodes are distinct, so the next read never meets this write.
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx[ftm_pkg::ADDR_W-1:0];
        mem_req.wr_data = mod_sum;
        if (up_next <= ftm_pkg::IDX_W'(bound)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = up_next[ftm_pkg::ADDR_W-1:0];
          idx_next        = up_next;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_QUERY: begin
        acc_next = mod_sum;
        if (dn_next != '0) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = dn_next[ftm_pkg::ADDR_W-1:0];
          idx_next        = dn_next;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_cnt;
        mem_req.wr_data = '0;
        clr_cnt_next    = clr_cnt + 1'b1;
        if (clr_cnt == '1) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    bound <= bound_next;
    addv  <= addv_next;
    acc   <= acc_next;
  end

endmodule

FILE: hw/rtl/fenwick_tree_mod_prefix_sum_core.sv
// Top level of the Fenwick prefix-sum core: stream ports, size register, tree memory.
//
// Input items arrive on the s_axis channel: tuser carries the opcode (add, query,
// clear), tdata carries the position and the addend. Query items produce one
// result item on m_axis holding the prefix sum modulo 1000000007; add and clear
// items produce nothing. The size register is written through cfg_we/cfg_wdata
// and bounds the upward walk of an add.
// The tree lives in one 4096 x 30 RAM with a registered read. An add over k nodes
// keeps the core busy with one read-modify-write per cycle; a query over k nodes
// (k = set bits of the position) raises its result on m_axis_tvalid in the cycle
// the input frees again. A clear item keeps the core busy, one RAM entry per cycle,
// until every entry is cleared. Reset sets the size to 4096 and runs the same
// clearing pass, during which s_axis_tready is low; configuration writes are
// taken throughout. A result waits in the output register while the receiver stalls;
// the core keeps taking items and only holds a later query at its end until that
// register frees.
module fenwick_tree_mod_prefix_sum_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // position [12:0], addend [42:13], zero [47:43]
  input  logic [1:0]  s_axis_tuser,   // opcode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // prefix_sum [29:0], zero [31:30]
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata       // size_in_use
);

  logic [ftm_pkg::SIZE_W-1:0] size_in_use;
  ftm_pkg::mem_req_t          mem_req;
  logic [ftm_pkg::VAL_W-1:0]  rd_data;
  logic                       res_valid;
  logic [ftm_pkg::VAL_W-1:0]  res_sum;
  logic                       res_ready;
  logic [ftm_pkg::VAL_W-1:0]  out_sum;

  // The size register may be written at any time; it is sampled when an add starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= ftm_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_in_use <= cfg_wdata;
    end
  end

  ftm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_opcode   (s_axis_tuser),
    .in_position (s_axis_tdata[12:0]),
    .in_addend   (s_axis_tdata[42:13]),
    .size_in_use (size_in_use),
    .rd_data     (rd_data),
    .mem_req     (mem_req),
    .res_valid   (res_valid),
    .res_sum     (res_sum),
    .res_ready   (res_ready)
  );

  ftm_ram #(
    .WIDTH (ftm_pkg::VAL_W),
    .DEPTH (ftm_pkg::DEPTH)
  ) u_tree_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (rd_data)
  );

  // Output register: a finished sum moves in whenever the register is empty or
  // being drained in the same cycle.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_sum <= res_sum;
    end
  end

  assign m_axis_tdata = {2'b00, out_sum};

endmodule

FILE: hw/rtl/ftm_checker.sv
// Port-level checker of the Fenwick prefix-sum core and its bind to the top level.
`include "fenwick_tree_mod_prefix_sum_core_assert.svh"

module ftm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `FTM_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result item dropped while stalled")
  `FTM_ASSERT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result item changed while stalled")
  `FTM_ASSERT(a_sum_range, clk, rst, m_axis_tvalid |-> (m_axis_tdata[29:0] < ftm_pkg::MODULUS) && (m_axis_tdata[31:30] == 2'b00), "prefix sum not reduced below the modulus")
  `FTM_ASSERT_NR(a_reset_clears, clk, rst |=> !s_axis_tready, "input taken during the clearing pass after reset")
  `FTM_ASSERT(a_clear_busy, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ftm_pkg::OP_CLEAR) |=> !s_axis_tready, "input taken right after a clear item")

endmodule

bind fenwick_tree_mod_prefix_sum_core ftm_checker u_ftm_checker (.*);
